>>> hdl/xtl_pkg.sv
// Shared types and constants for the XYZ to CIELAB converter.
// No dependencies; imported by every module of the block.
package xtl_pkg;

    // Field widths
    localparam int unsigned VAL_W   = 24;   // Q8.16 tristimulus and white values
    localparam int unsigned RATIO_W = 24;   // Q4.20 ratio
    localparam int unsigned F_W     = 22;   // Q.20 curve value
    localparam int unsigned LIN_W   = 19;   // linear segment result
    localparam int unsigned NUM_W   = 30;   // linear numerator
    localparam int unsigned PROD_W  = 61;   // numerator times reciprocal
    localparam int unsigned L_W     = 21;
    localparam int unsigned A_W     = 24;
    localparam int unsigned B_W     = 22;

    // Pipeline depths
    localparam int unsigned DIV_STEPS = 24; // one quotient bit per stage
    localparam int unsigned CR_STEPS  = 22; // one root bit per stage
    localparam int unsigned MRG_STAGES = 2;
    localparam int unsigned LATENCY   = (DIV_STEPS + 1) + (CR_STEPS + 1) + MRG_STAGES;

    // Curve constants
    localparam logic [RATIO_W-1:0] LIN_LIMIT  = 24'd9286;      // t*24389 > 216*2^20
    localparam logic [14:0]        LIN_MUL    = 15'd24389;
    localparam logic [NUM_W-1:0]   LIN_OFFSET = 30'd452986398; // 432*2^20 + 1566
    localparam logic [30:0]        LIN_RECIP  = 31'd1404229410; // ceil(2^42 / 3132)
    localparam int unsigned        LIN_SHIFT  = 42;

    // Reset values of the white registers (D65)
    localparam logic [VAL_W-1:0] WHITE_X_RST = 24'd6229000;
    localparam logic [VAL_W-1:0] WHITE_Y_RST = 24'd6553600;
    localparam logic [VAL_W-1:0] WHITE_Z_RST = 24'd7135756;

    // Register indexes
    typedef enum logic [1:0] {
        REG_WHITE_X = 2'd0,
        REG_WHITE_Y = 2'd1,
        REG_WHITE_Z = 2'd2
    } reg_idx_t;

    // What one lane hands to the merging stage
    typedef struct packed {
        logic [F_W-1:0] f;
        logic           sat;
    } lane_res_t;

endpackage

>>> hdl/xtl_divider.sv
// Pipelined restoring divider: ratio = floor((v << 20) / w), clamped to Q4.20.
// Depends on xtl_pkg.
module xtl_divider (
    input  logic                        clk,
    input  logic                        en,
    input  logic [xtl_pkg::VAL_W-1:0]   dividend,
    input  logic [xtl_pkg::VAL_W-1:0]   divisor,
    output logic [xtl_pkg::RATIO_W-1:0] ratio,
    output logic                        sat
);
    import xtl_pkg::*;

    logic [VAL_W-1:0]   rem_reg [0:DIV_STEPS];
    logic [RATIO_W-1:0] q_reg   [0:DIV_STEPS];
    logic [VAL_W-1:0]   low_reg [0:DIV_STEPS];
    logic               sat_reg [0:DIV_STEPS];

    // Entry: quotient of 16 or more (or zero divisor) iff v >= 16*w
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {4'b0, dividend[VAL_W-1:4]};
            low_reg[0] <= {dividend[3:0], 20'b0};
            q_reg[0]   <= '0;
            sat_reg[0] <= {4'b0, dividend} >= {divisor, 4'b0};
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [VAL_W:0]   trial;
        logic             ge;
        logic [VAL_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][VAL_W-1]};
            ge       = trial >= {1'b0, divisor};
            rem_next = ge ? VAL_W'(trial - {1'b0, divisor}) : trial[VAL_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                q_reg[k+1]   <= {q_reg[k][RATIO_W-2:0], ge};
                low_reg[k+1] <= {low_reg[k][VAL_W-2:0], 1'b0};
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    assign ratio = sat_reg[DIV_STEPS] ? '1 : q_reg[DIV_STEPS];
    assign sat   = sat_reg[DIV_STEPS];

endmodule

>>> hdl/xtl_cube_root.sv
// CIELAB curve for one lane: pipelined cube root with the linear segment alongside.
// Depends on xtl_pkg.
module xtl_cube_root (
    input  logic                        clk,
    input  logic                        en,
    input  logic [xtl_pkg::RATIO_W-1:0] ratio,
    input  logic                        sat_in,
    output xtl_pkg::lane_res_t          res
);
    import xtl_pkg::*;

    logic [RATIO_W-1:0] t_reg   [0:CR_STEPS];
    logic               sat_reg [0:CR_STEPS];
    logic [F_W-1:0]     r_reg   [0:CR_STEPS];
    logic [2*F_W-1:0]   r2_reg  [0:CR_STEPS];
    logic [63:0]        r3_reg  [0:CR_STEPS];
    logic [NUM_W-1:0]   num_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [LIN_W-1:0]   lq_reg  [2:CR_STEPS];
    logic [NUM_W-1:0]   num_next;

    // Linear numerator; only meaningful when t is at or below the limit
    assign num_next = NUM_W'(ratio[13:0]) * NUM_W'(LIN_MUL) + LIN_OFFSET;

    // Entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= ratio;
            sat_reg[0] <= sat_in;
            r_reg[0]   <= '0;
            r2_reg[0]  <= '0;
            r3_reg[0]  <= '0;
            num_reg    <= num_next;
        end
    end

    // Divide by 3132 through the reciprocal, exact over the numerator range
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= PROD_W'(num_reg) * PROD_W'(LIN_RECIP);
            lq_reg[2] <= prod_reg[PROD_W-1:LIN_SHIFT];
        end
    end

    for (genvar j = 2; j < CR_STEPS; j++)
    begin : g_lin
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lq_reg[j+1] <= lq_reg[j];
            end
        end
    end

    // One root bit per stage, tracking r, r^2 and r^3 incrementally
    for (genvar j = 0; j < CR_STEPS; j++)
    begin : g_root
        localparam int unsigned B = CR_STEPS - 1 - j;
        logic [67:0]      c3;
        logic [2*F_W-1:0] c2;
        logic             take;

        always_comb
        begin
            c3 = 68'(r3_reg[j])
               + ((68'(r2_reg[j]) + (68'(r2_reg[j]) << 1)) << B)
               + ((68'(r_reg[j]) + (68'(r_reg[j]) << 1)) << (2 * B))
               + (68'(1) << (3 * B));
            c2 = r2_reg[j] + ((2*F_W)'(r_reg[j]) << (B + 1)) + ((2*F_W)'(1) << (2 * B));
            take = c3 <= {4'b0, t_reg[j], 40'b0};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[j+1]   <= t_reg[j];
                sat_reg[j+1] <= sat_reg[j];
                r_reg[j+1]   <= take ? (r_reg[j] | (F_W'(1) << B)) : r_reg[j];
                r2_reg[j+1]  <= take ? c2 : r2_reg[j];
                r3_reg[j+1]  <= take ? c3[63:0] : r3_reg[j];
            end
        end
    end

    // Branch select
    always_comb
    begin
        res.sat = sat_reg[CR_STEPS];
        if (t_reg[CR_STEPS] > LIN_LIMIT)
        begin
            res.f = r_reg[CR_STEPS];
        end
        else
        begin
            res.f = {{(F_W-LIN_W){1'b0}}, lq_reg[CR_STEPS]};
        end
    end

endmodule

>>> hdl/xtl_merge.sv
// Merging stage: combines the three lane curves into L*, a*, b* in Q.12.
// Depends on xtl_pkg.
module xtl_merge (
    input  logic                        clk,
    input  logic                        en,
    input  xtl_pkg::lane_res_t          fx,
    input  xtl_pkg::lane_res_t          fy,
    input  xtl_pkg::lane_res_t          fz,
    output logic [xtl_pkg::L_W-1:0]     lightness,
    output logic signed [xtl_pkg::A_W-1:0] red_green,
    output logic signed [xtl_pkg::B_W-1:0] yellow_blue,
    output logic                        saturated
);
    import xtl_pkg::*;

    logic signed [29:0] lq_reg;
    logic signed [32:0] a_reg;
    logic signed [31:0] b_reg;
    logic               sat_reg;

    logic signed [29:0] lq_next;
    logic signed [32:0] a_next;
    logic signed [31:0] b_next;

    logic [29:0]        l_round;
    logic [32:0]        a_mag;
    logic [32:0]        a_rnd;
    logic [31:0]        b_mag;
    logic [31:0]        b_rnd;
    logic [L_W-1:0]     light_next;

    // Scaled differences
    always_comb
    begin
        lq_next = 30'(signed'({8'b0, fy.f}) * 30'sd116) - 30'sd16777216;
        a_next  = 33'(signed'({11'b0, fx.f}) - signed'({11'b0, fy.f})) * 33'sd500;
        b_next  = 32'(signed'({10'b0, fy.f}) - signed'({10'b0, fz.f})) * 32'sd200;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lq_reg  <= lq_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            sat_reg <= fx.sat | fy.sat | fz.sat;
        end
    end

    // Round to Q.12, halves away from zero; clamp lightness
    always_comb
    begin
        l_round = (30'(lq_reg) + 30'd128) >> 8;
        if (lq_reg <= 30'sd0)
        begin
            light_next = '0;
        end
        else if (l_round > 30'(2**L_W - 1))
        begin
            light_next = '1;
        end
        else
        begin
            light_next = l_round[L_W-1:0];
        end
        a_mag = a_reg[32] ? 33'(-a_reg) : 33'(a_reg);
        a_rnd = (a_mag + 33'd128) >> 8;
        if (a_reg[32])
        begin
            a_rnd = 33'(-a_rnd);
        end
        b_mag = b_reg[31] ? 32'(-b_reg) : 32'(b_reg);
        b_rnd = (b_mag + 32'd128) >> 8;
        if (b_reg[31])
        begin
            b_rnd = 32'(-b_rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lightness   <= light_next;
            red_green   <= signed'(a_rnd[A_W-1:0]);
            yellow_blue <= signed'(b_rnd[B_W-1:0]);
            saturated   <= sat_reg;
        end
    end

endmodule

>>> hdl/xyz_to_lab_converter_top.sv
// Top level of the XYZ to CIELAB converter: white registers, three lanes, merge.
// Depends on xtl_pkg, xtl_divider, xtl_cube_root and xtl_merge.
//
// Usage:
//   Input channel in_valid/in_ready carries one XYZ colour per request
//   (x_value, y_value, z_value, unsigned Q8.16). Output channel
//   out_valid/out_ready returns lightness, red_green, yellow_blue (Q.12)
//   and the saturated flag, one result per request, in order.
//   Configuration channel cfg_valid/cfg_ready writes the reference white:
//   index 0 X, 1 Y, 2 Z; index 3 is ignored. cfg_ready is always high;
//   write only while no request is in flight.
//   The pipeline has 25 divider stages (an entry stage, then one per quotient
//   bit), 23 cube-root stages (entry plus one per root bit) and 2 merge stages.
//   Throughput is one request per cycle without stalls; X, Y, Z have own lanes.
//   When the receiver stalls the whole pipeline holds; in_ready stays high
//   while the output register is empty or being taken.
//   Reset clears all valid flags and loads the D65 white point.
module xyz_to_lab_converter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [xtl_pkg::VAL_W-1:0]      x_value,
    input  logic [xtl_pkg::VAL_W-1:0]      y_value,
    input  logic [xtl_pkg::VAL_W-1:0]      z_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [xtl_pkg::L_W-1:0]        lightness,
    output logic signed [xtl_pkg::A_W-1:0] red_green,
    output logic signed [xtl_pkg::B_W-1:0] yellow_blue,
    output logic                           saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [xtl_pkg::VAL_W-1:0]      cfg_data
);
    import xtl_pkg::*;

    logic [VAL_W-1:0]   white_x_reg;
    logic [VAL_W-1:0]   white_y_reg;
    logic [VAL_W-1:0]   white_z_reg;
    logic [LATENCY-1:0] vld_reg;
    logic               en;

    logic [VAL_W-1:0]   lane_v     [0:2];
    logic [VAL_W-1:0]   lane_w     [0:2];
    logic [RATIO_W-1:0] lane_ratio [0:2];
    logic               lane_sat   [0:2];
    lane_res_t          lane_res   [0:2];

    assign cfg_ready = 1'b1;

    // White point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_x_reg <= WHITE_X_RST;
            white_y_reg <= WHITE_Y_RST;
            white_z_reg <= WHITE_Z_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WHITE_X: white_x_reg <= cfg_data;
                REG_WHITE_Y: white_y_reg <= cfg_data;
                REG_WHITE_Z: white_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a finished result is held back
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], in_valid};
        end
    end

    assign lane_v[0] = x_value;
    assign lane_v[1] = y_value;
    assign lane_v[2] = z_value;
    assign lane_w[0] = white_x_reg;
    assign lane_w[1] = white_y_reg;
    assign lane_w[2] = white_z_reg;

    // One lane per tristimulus channel
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        xtl_divider u_div (
            .clk      (clk),
            .en       (en),
            .dividend (lane_v[i]),
            .divisor  (lane_w[i]),
            .ratio    (lane_ratio[i]),
            .sat      (lane_sat[i])
        );

        xtl_cube_root u_curve (
            .clk    (clk),
            .en     (en),
            .ratio  (lane_ratio[i]),
            .sat_in (lane_sat[i]),
            .res    (lane_res[i])
        );
    end

    xtl_merge u_merge (
        .clk         (clk),
        .en          (en),
        .fx          (lane_res[0]),
        .fy          (lane_res[1]),
        .fz          (lane_res[2]),
        .lightness   (lightness),
        .red_green   (red_green),
        .yellow_blue (yellow_blue),
        .saturated   (saturated)
    );

`ifndef SYNTHESIS
    // Lightness never exceeds L* = 277 in Q.12
    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lightness <= 21'd1134592)
        else $error("lightness out of range");

    // Input is only refused while a result waits at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // Unsaturated a* stays within +-1260 in Q.12
    a_rg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !saturated) |->
            (red_green <= 24'sd5160960 && red_green >= -24'sd5160960))
        else $error("red_green out of range");

    // A stall-free cycle with no request puts a bubble into the first pipeline stage
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !in_valid) |=> !vld_reg[0])
        else $error("bubble not propagated");
`endif

endmodule
